### hdl/text_console_char_writer_defines.svh
// assertion macros for the text console character writer
`ifndef TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define TCCW_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tccw assertion failed");

// next-cycle implication
`define TCCW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tccw assertion failed");

`else

`define TCCW_ASSERT_IMP(label, clk, rst, ante, cons)
`define TCCW_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### hdl/tccw_pkg.sv
// shared types, constants and helpers of the text console character writer
`timescale 1ns / 1ps

package tccw_pkg;

   localparam int DEF_SCREEN_ROWS    = 25;
   localparam int DEF_SCREEN_COLUMNS = 80;

   localparam int KIND_W = 2;
   localparam int CHAR_W = 8;
   localparam int BG_W   = 4;
   localparam int IDX_W  = 11;
   localparam int POS_W  = 11;
   localparam int ATTR_W = 8;
   localparam int CELL_W = 16;

   localparam int TAB_STOP = 8;

   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'd9;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_RETURN    = 8'd13;
   localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;

   localparam logic [3:0]        GREY_FG    = 4'h7;
   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
   localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;

   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE = 2'd0,
      KIND_CLEAR = 2'd1,
      KIND_READ  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP,
      ST_SCROLL,
      ST_FILL
   } state_type;

   typedef struct packed {
      logic cell_write;
      logic scroll;
   } step_flags_type;

   function automatic logic [CELL_W-1:0] make_cell(input logic [ATTR_W-1:0] attr,
                                                   input logic [CHAR_W-1:0] ch);
      return {attr, ch};
   endfunction

endpackage

### hdl/tccw_cursor_step.sv
// cursor update and cell write decision for one character transaction
`timescale 1ns / 1ps

module tccw_cursor_step #(
   parameter int SCREEN_ROWS    = tccw_pkg::DEF_SCREEN_ROWS,
   parameter int SCREEN_COLUMNS = tccw_pkg::DEF_SCREEN_COLUMNS
) (
   input  logic [$clog2(SCREEN_COLUMNS)-1:0] col_i,
   input  logic [$clog2(SCREEN_ROWS)-1:0]    row_i,
   input  logic [tccw_pkg::CHAR_W-1:0]       char_i,
   input  logic [tccw_pkg::ATTR_W-1:0]       attr_i,
   output logic [$clog2(SCREEN_COLUMNS)-1:0] col_o,
   output logic [$clog2(SCREEN_ROWS)-1:0]    row_o,
   output logic [$clog2(SCREEN_COLUMNS)-1:0] wr_col_o,
   output logic [$clog2(SCREEN_ROWS)-1:0]    wr_row_o,
   output logic [tccw_pkg::CELL_W-1:0]       wr_data_o,
   output tccw_pkg::step_flags_type          flags_o
);
   import tccw_pkg::*;

   localparam int CW = $clog2(SCREEN_COLUMNS);
   localparam int RW = $clog2(SCREEN_ROWS);

   always_comb begin
      logic [CW:0] col_t;
      logic [RW:0] row_t;
      col_t              = {1'b0, col_i};
      row_t              = {1'b0, row_i};
      wr_col_o           = col_i;
      wr_row_o           = row_i;
      wr_data_o          = make_cell(attr_i, char_i);
      flags_o.cell_write = 1'b0;
      unique case (char_i)
         CHAR_NEWLINE: begin
            col_t = '0;
            row_t = row_t + (RW+1)'(1);
         end
         CHAR_RETURN: begin
            col_t = '0;
         end
         CHAR_TAB: begin
            col_t = (col_t + (CW+1)'(TAB_STOP)) & ~(CW+1)'(TAB_STOP - 1);
         end
         CHAR_BACKSPACE: begin
            // back across the line start, stays put at home
            if (col_i != '0) begin
               col_t = col_t - (CW+1)'(1);
            end else if (row_i != '0) begin
               row_t = row_t - (RW+1)'(1);
               col_t = (CW+1)'(SCREEN_COLUMNS - 1);
            end
            flags_o.cell_write = 1'b1;
            wr_col_o           = col_t[CW-1:0];
            wr_row_o           = row_t[RW-1:0];
            wr_data_o          = make_cell(attr_i, BLANK_CHAR);
         end
         default: begin
            flags_o.cell_write = 1'b1;
            col_t              = col_t + (CW+1)'(1);
         end
      endcase
      if (col_t >= (CW+1)'(SCREEN_COLUMNS)) begin
         col_t = '0;
         row_t = row_t + (RW+1)'(1);
      end
      flags_o.scroll = (row_t >= (RW+1)'(SCREEN_ROWS));
      row_o          = flags_o.scroll ? RW'(SCREEN_ROWS - 1) : row_t[RW-1:0];
      col_o          = col_t[CW-1:0];
   end

endmodule

### hdl/text_console_char_writer.sv
// text console character writer: top level with the screen cell memory
// sequence: accept, the execute state, then the response strobe; a write that scrolls
// runs a scroll pass first (rows move up, the last row is blanked), and a clear runs a
// fill pass over every cell first; no new transaction is accepted until idle again
// reset: synchronous; a clearing pass writes 0x0720 to every cell with busy high;
// the receiver cannot stall, results are strobed
`timescale 1ns / 1ps
`include "text_console_char_writer_defines.svh"

module text_console_char_writer #(
   parameter int SCREEN_ROWS    = tccw_pkg::DEF_SCREEN_ROWS,
   parameter int SCREEN_COLUMNS = tccw_pkg::DEF_SCREEN_COLUMNS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [tccw_pkg::KIND_W-1:0]  req_kind,
   input  logic [tccw_pkg::CHAR_W-1:0]  req_char_code,
   input  logic [tccw_pkg::BG_W-1:0]    req_clear_background,
   input  logic [tccw_pkg::IDX_W-1:0]   req_cell_index,
   output logic                         rsp_valid,
   output logic [tccw_pkg::POS_W-1:0]   rsp_cursor_position,
   output logic [tccw_pkg::CELL_W-1:0]  rsp_cell_data,
   input  logic                         csr_wr_en,
   input  logic [tccw_pkg::ATTR_W-1:0]  csr_wr_data
);
   import tccw_pkg::*;

   localparam int CELL_COUNT = SCREEN_ROWS * SCREEN_COLUMNS;
   localparam int CW         = $clog2(SCREEN_COLUMNS);
   localparam int RW         = $clog2(SCREEN_ROWS);
   localparam int AW         = $clog2(CELL_COUNT);
   localparam int SW         = $clog2(CELL_COUNT + 1);

   state_type           state_ff, state_in;
   logic [SW-1:0]       scan_ff, scan_in;
   logic [CW-1:0]       col_ff, col_in;
   logic [RW-1:0]       row_ff, row_in;
   logic [ATTR_W-1:0]   attr_ff, attr_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [CHAR_W-1:0]   char_ff, char_in;
   logic [BG_W-1:0]     bg_ff, bg_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [CELL_W-1:0]   fill_data_ff, fill_data_in;
   logic                fill_init_ff, fill_init_in;
   logic                rd_hit_ff, rd_hit_in;
   logic [CELL_W-1:0]   mem_rdata_ff;

   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   logic [CELL_W-1:0]   mem_wdata;
   logic                mem_re;
   logic [AW-1:0]       mem_raddr;

   logic [CELL_W-1:0]   cells [CELL_COUNT];

   logic [CW-1:0]       step_col;
   logic [RW-1:0]       step_row;
   logic [CW-1:0]       step_wr_col;
   logic [RW-1:0]       step_wr_row;
   logic [CELL_W-1:0]   step_wr_data;
   step_flags_type      step_flags;

   logic                accept;
   logic                scroll_done;
   logic                fill_done;
   logic [AW-1:0]       cursor_lin;
   logic [CELL_W-1:0]   scroll_blank;

   tccw_cursor_step #(
      .SCREEN_ROWS    (SCREEN_ROWS),
      .SCREEN_COLUMNS (SCREEN_COLUMNS)
   ) u_cursor_step (
      .col_i     (col_ff),
      .row_i     (row_ff),
      .char_i    (char_ff),
      .attr_i    (attr_ff),
      .col_o     (step_col),
      .row_o     (step_row),
      .wr_col_o  (step_wr_col),
      .wr_row_o  (step_wr_row),
      .wr_data_o (step_wr_data),
      .flags_o   (step_flags)
   );

   assign accept       = start && (state_ff == ST_IDLE);
   assign scroll_done  = (scan_ff == SW'(CELL_COUNT));
   assign fill_done    = (scan_ff == SW'(CELL_COUNT - 1));
   assign cursor_lin   = AW'(row_ff) * AW'(SCREEN_COLUMNS) + AW'(col_ff);
   assign scroll_blank = make_cell(attr_ff, BLANK_CHAR);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            priority if (kind_ff == KIND_CLEAR) begin
               state_in = ST_FILL;
            end else if (kind_ff == KIND_WRITE && step_flags.scroll) begin
               state_in = ST_SCROLL;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         ST_SCROLL: begin
            if (scroll_done) begin
               state_in = ST_RESP;
            end
         end
         ST_FILL: begin
            if (fill_done) begin
               state_in = fill_init_ff ? ST_IDLE : ST_RESP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      busy                = (state_ff != ST_IDLE);
      rsp_valid           = (state_ff == ST_RESP);
      rsp_cursor_position = POS_W'(cursor_lin);
      rsp_cell_data       = (rsp_valid && rd_hit_ff) ? mem_rdata_ff : '0;
   end

   // datapath and memory control
   always_comb begin
      scan_in      = scan_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      attr_in      = csr_wr_en ? csr_wr_data : attr_ff;
      kind_in      = kind_ff;
      char_in      = char_ff;
      bg_in        = bg_ff;
      idx_in       = idx_ff;
      fill_data_in = fill_data_ff;
      fill_init_in = fill_init_ff;
      rd_hit_in    = rd_hit_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = step_wr_data;
      mem_re       = 1'b0;
      mem_raddr    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in = req_kind;
               char_in = req_char_code;
               bg_in   = req_clear_background;
               idx_in  = req_cell_index;
            end
         end
         ST_EXEC: begin
            rd_hit_in = 1'b0;
            scan_in   = '0;
            unique case (kind_type'(kind_ff))
               KIND_WRITE: begin
                  col_in    = step_col;
                  row_in    = step_row;
                  mem_we    = step_flags.cell_write;
                  mem_waddr = AW'(step_wr_row) * AW'(SCREEN_COLUMNS) + AW'(step_wr_col);
                  mem_wdata = step_wr_data;
               end
               KIND_CLEAR: begin
                  col_in       = '0;
                  row_in       = '0;
                  fill_data_in = make_cell({bg_ff, GREY_FG}, BLANK_CHAR);
               end
               KIND_READ: begin
                  rd_hit_in = (32'(idx_ff) < 32'(CELL_COUNT));
                  mem_re    = rd_hit_in;
                  mem_raddr = AW'(idx_ff);
               end
               default: begin
                  rd_hit_in = 1'b0;
               end
            endcase
         end
         ST_RESP: begin
         end
         ST_SCROLL: begin
            // read one row ahead, write the registered cell to the row above in the next cycle
            mem_re    = (scan_ff < SW'(CELL_COUNT - SCREEN_COLUMNS));
            mem_raddr = AW'(scan_ff + SW'(SCREEN_COLUMNS));
            mem_we    = (scan_ff != '0);
            mem_waddr = AW'(scan_ff - SW'(1));
            mem_wdata = (scan_ff <= SW'(CELL_COUNT - SCREEN_COLUMNS)) ?
                        mem_rdata_ff : scroll_blank;
            scan_in   = scan_ff + SW'(1);
         end
         ST_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(scan_ff);
            mem_wdata = fill_data_ff;
            scan_in   = scan_ff + SW'(1);
            if (fill_done) begin
               fill_init_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         scan_ff      <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         attr_ff      <= RESET_ATTR;
         fill_data_ff <= RESET_CELL;
         fill_init_ff <= 1'b1;
         rd_hit_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         attr_ff      <= attr_in;
         fill_data_ff <= fill_data_in;
         fill_init_ff <= fill_init_in;
         rd_hit_ff    <= rd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      char_ff <= char_in;
      bg_ff   <= bg_in;
      idx_ff  <= idx_in;
   end

   // screen cell memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cells[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= cells[mem_raddr];
      end
   end

   `TCCW_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `TCCW_ASSERT_NEXT(a_rsp_then_idle, clock, reset, rsp_valid, !busy)
   `TCCW_ASSERT_IMP(a_col_range, clock, reset, 1'b1, 32'(col_ff) < SCREEN_COLUMNS)
   `TCCW_ASSERT_IMP(a_row_range, clock, reset, 1'b1, 32'(row_ff) < SCREEN_ROWS)
   `TCCW_ASSERT_IMP(a_waddr_range, clock, reset, mem_we, 32'(mem_waddr) < CELL_COUNT)

endmodule
